@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands included by the top rtl file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LGS_ASSERT_IMPL(lbl, clk_i, rst_n_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define LGS_ASSERT_NEXT(lbl, clk_i, rst_n_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ rtl/lgs_pkg.sv @@
// ---------------------------------------------------------------------------
// lgs_pkg
// types and constants of the life grid generation step block
// ---------------------------------------------------------------------------
package lgs_pkg;

	localparam int MaxRows = 64;
	localparam int MaxCols = 64;
	localparam int RowW    = $clog2(MaxRows);
	localparam int ColW    = $clog2(MaxCols);
	localparam int CntW    = 7;
	localparam int InW     = 16;
	localparam int OutW    = 8;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_STEP  = 2'd2,
		CMD_CHECK = 2'd3
	} lgs_cmd_t;

	localparam logic REG_ROW_COUNT = 1'b0;
	localparam logic REG_COL_COUNT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACCESS,
		ST_SWEEP,
		ST_RESP
	} lgs_state_t;

	// window control shared by every cell of the row
	typedef struct packed {
		logic clr;
		logic shift;
	} lgs_win_ctl_t;

endpackage

@@ rtl/life_grid_generation_step_top.sv @@
// ---------------------------------------------------------------------------
// life_grid_generation_step_top
// bounded b3/s23 life grid with cell access, step and stability check
//
// channel  dir  payload (low bit first)
// s_*      in   cmd[1:0], cell_row[7:2], cell_col[13:8], cell_value[14]
// m_*      out  read_value[0], stable[1]
// cfg_*    in   cfg_index 0 row_count, 1 col_count; cfg_data[6:0]
//
// read and write requests read one grid row, and a write stores it back with
// its cell replaced; step and check pass one row per cycle through the cell
// chain behind the row ram's registered read port.
// reset clears all grid rows through per-row valid bits, no clearing pass.
// a new request is taken while a result waits in the output register; a
// finished request waits for that register to empty.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module life_grid_generation_step_top
	import lgs_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [InW-1:0]  s_tdata,   // cmd, cell_row, cell_col, cell_value
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [OutW-1:0] m_tdata,   // read_value, stable
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic            cfg_index,
	input  logic [CntW-1:0] cfg_data
);

	lgs_state_t state_q, state_d;

	logic [CntW-1:0] row_cnt_q, col_cnt_q;
	logic [CntW-1:0] rows_eff, cols_eff;
	logic [MaxCols-1:0] act_mask;

	lgs_cmd_t       s_cmd;
	logic [RowW-1:0] s_row;
	logic [ColW-1:0] s_col;
	logic            s_val;
	logic            s_fire, s_inside, s_sweep;

	lgs_cmd_t        cmd_q;
	logic [RowW-1:0] row_q;
	logic [ColW-1:0] col_q;
	logic            val_q, inside_q;

	logic [CntW-1:0] issued_q, wr_row_q;
	logic            tok_s1, tok_zero_s1, rd_vld_s1;
	logic            prev_shift_q, win_vld_q, stable_q;
	logic            sweep_issue, sweep_done;

	logic [MaxRows-1:0] row_vld_q;
	logic [MaxCols-1:0] raw_below_q, raw_cur_q;
	logic [MaxCols-1:0] rd_word, row_in, next_row;
	logic               row_changed;
	lgs_win_ctl_t       win_ctl;

	logic               ram_we, ram_re;
	logic [RowW-1:0]    ram_waddr, ram_raddr;
	logic [MaxCols-1:0] ram_wdata, ram_rdata;

	logic res_rd_q, res_st_q;
	logic out_vld_q, out_rd_q, out_st_q, out_free;

	// effective counts
	always_comb begin
		if (row_cnt_q == '0) begin
			rows_eff = CntW'(1);
		end else if (row_cnt_q > CntW'(MaxRows)) begin
			rows_eff = CntW'(MaxRows);
		end else begin
			rows_eff = row_cnt_q;
		end
		if (col_cnt_q == '0) begin
			cols_eff = CntW'(1);
		end else if (col_cnt_q > CntW'(MaxCols)) begin
			cols_eff = CntW'(MaxCols);
		end else begin
			cols_eff = col_cnt_q;
		end
		for (int i = 0; i < MaxCols; i++) begin
			act_mask[i] = CntW'(i) < cols_eff;
		end
	end

	assign s_cmd    = lgs_cmd_t'(s_tdata[1:0]);
	assign s_row    = s_tdata[7:2];
	assign s_col    = s_tdata[13:8];
	assign s_val    = s_tdata[14];
	assign s_fire   = s_tvalid & s_tready;
	assign s_sweep  = (s_cmd == CMD_STEP) | (s_cmd == CMD_CHECK);
	assign s_inside = ({1'b0, s_row} < rows_eff) & ({1'b0, s_col} < cols_eff);

	assign rd_word     = rd_vld_s1 ? ram_rdata : '0;
	assign row_in      = tok_zero_s1 ? '0 : (rd_word & act_mask);
	assign sweep_issue = (state_q == ST_SWEEP) & (issued_q <= rows_eff);
	assign sweep_done  = win_vld_q & (wr_row_q == rows_eff - CntW'(1));
	assign out_free    = ~out_vld_q | m_tready;

	assign cfg_ready = 1'b1;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_fire) begin
					state_d = s_sweep ? ST_SWEEP : ST_ACCESS;
				end
			end
			ST_ACCESS: begin
				state_d = ST_RESP;
			end
			ST_SWEEP: begin
				if (sweep_done) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs: handshake, ram ports, window control
	always_comb begin
		s_tready      = 1'b0;
		ram_re        = 1'b0;
		ram_raddr     = s_row;
		ram_we        = 1'b0;
		ram_waddr     = row_q;
		ram_wdata     = rd_word;
		ram_wdata[col_q] = val_q;
		win_ctl.clr   = 1'b0;
		win_ctl.shift = tok_s1;
		case (state_q)
			ST_IDLE: begin
				s_tready    = 1'b1;
				ram_re      = s_tvalid & ~s_sweep & s_inside;
				win_ctl.clr = s_tvalid & s_sweep;
			end
			ST_ACCESS: begin
				ram_we = (cmd_q == CMD_WRITE) & inside_q;
			end
			ST_SWEEP: begin
				ram_re    = sweep_issue & (issued_q < rows_eff);
				ram_raddr = issued_q[RowW-1:0];
				ram_we    = win_vld_q & (cmd_q == CMD_STEP);
				ram_waddr = wr_row_q[RowW-1:0];
				ram_wdata = (raw_cur_q & ~act_mask) | next_row;
			end
			ST_RESP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			row_cnt_q    <= CntW'(64);
			col_cnt_q    <= CntW'(64);
			row_vld_q    <= '0;
			issued_q     <= '0;
			wr_row_q     <= '0;
			tok_s1       <= 1'b0;
			tok_zero_s1  <= 1'b0;
			prev_shift_q <= 1'b0;
			win_vld_q    <= 1'b0;
			stable_q     <= 1'b1;
			out_vld_q    <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_valid & cfg_ready) begin
				case (cfg_index)
					REG_ROW_COUNT: row_cnt_q <= cfg_data;
					REG_COL_COUNT: col_cnt_q <= cfg_data;
					default: begin
					end
				endcase
			end

			if (ram_we) begin
				row_vld_q[ram_waddr] <= 1'b1;
			end

			if (s_fire) begin
				issued_q     <= '0;
				wr_row_q     <= '0;
				prev_shift_q <= 1'b0;
				stable_q     <= 1'b1;
			end else begin
				if (sweep_issue) begin
					issued_q <= issued_q + CntW'(1);
				end
				if (tok_s1) begin
					prev_shift_q <= 1'b1;
				end
				if (win_vld_q) begin
					wr_row_q <= wr_row_q + CntW'(1);
					stable_q <= stable_q & ~row_changed;
				end
			end
			tok_s1      <= sweep_issue;
			tok_zero_s1 <= issued_q == rows_eff;
			win_vld_q   <= tok_s1 & prev_shift_q;

			if (state_q == ST_RESP && out_free) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// payload, read-valid, window and result registers
	always_ff @(posedge clk) begin
		if (s_fire) begin
			cmd_q    <= s_cmd;
			row_q    <= s_row;
			col_q    <= s_col;
			val_q    <= s_val;
			inside_q <= s_inside;
		end
		if (ram_re) begin
			rd_vld_s1 <= row_vld_q[ram_raddr];
		end
		if (win_ctl.clr) begin
			raw_below_q <= '0;
			raw_cur_q   <= '0;
		end else if (win_ctl.shift) begin
			raw_below_q <= tok_zero_s1 ? '0 : rd_word;
			raw_cur_q   <= raw_below_q;
		end
		if (state_q == ST_ACCESS) begin
			res_rd_q <= (cmd_q == CMD_READ) & inside_q & rd_word[col_q];
			res_st_q <= 1'b0;
		end else if (state_q == ST_SWEEP && sweep_done) begin
			res_rd_q <= 1'b0;
			res_st_q <= stable_q & ~row_changed;
		end
		if (state_q == ST_RESP && out_free) begin
			out_rd_q <= res_rd_q;
			out_st_q <= res_st_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {{(OutW-2){1'b0}}, out_st_q, out_rd_q};

	lgs_ram #(
		.Width (MaxCols),
		.Depth (MaxRows)
	) u_grid_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	lgs_cell_row u_cell_row (
		.clk      (clk),
		.ctl      (win_ctl),
		.row_in   (row_in),
		.act_mask (act_mask),
		.next_row (next_row),
		.changed  (row_changed)
	);

	`LGS_ASSERT_IMPL(a_write_behind_read, clk, arst_n,
		ram_we && state_q == ST_SWEEP, issued_q > wr_row_q)
	`LGS_ASSERT_NEXT(a_result_waits, clk, arst_n,
		state_q == ST_RESP && m_tvalid && !m_tready, state_q == ST_RESP && m_tvalid)
	`LGS_ASSERT_IMPL(a_window_in_sweep, clk, arst_n,
		win_vld_q, state_q == ST_SWEEP)

endmodule

@@ rtl/lgs_ram.sv @@
// ---------------------------------------------------------------------------
// lgs_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
module lgs_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/lgs_cell.sv @@
// ---------------------------------------------------------------------------
// lgs_cell
// one grid column of the sweep window with its b3/s23 rule
// ---------------------------------------------------------------------------
module lgs_cell
	import lgs_pkg::*;
(
	input  logic         clk,
	input  lgs_win_ctl_t ctl,
	input  logic         in_bit,
	input  logic         act,
	input  logic [2:0]   nb_left,
	input  logic [2:0]   nb_right,
	output logic [2:0]   col_bits,
	output logic         next_bit,
	output logic         changed
);

	logic       above_q;
	logic       cur_q;
	logic       below_q;
	logic [3:0] n;

	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			above_q <= 1'b0;
			cur_q   <= 1'b0;
			below_q <= 1'b0;
		end else if (ctl.shift) begin
			above_q <= cur_q;
			cur_q   <= below_q;
			below_q <= in_bit;
		end
	end

	// bit 0 above, bit 1 current, bit 2 below
	assign col_bits = {below_q, cur_q, above_q};

	assign n = {3'b0, nb_left[0]} + {3'b0, nb_left[1]} + {3'b0, nb_left[2]}
		+ {3'b0, nb_right[0]} + {3'b0, nb_right[1]} + {3'b0, nb_right[2]}
		+ {3'b0, above_q} + {3'b0, below_q};

	assign next_bit = act & ((n == 4'd3) | (cur_q & (n == 4'd2)));
	assign changed  = next_bit ^ cur_q;

endmodule

@@ rtl/lgs_cell_row.sv @@
// ---------------------------------------------------------------------------
// lgs_cell_row
// chain of column cells forming the three-row sweep window
// ---------------------------------------------------------------------------
module lgs_cell_row
	import lgs_pkg::*;
(
	input  logic               clk,
	input  lgs_win_ctl_t       ctl,
	input  logic [MaxCols-1:0] row_in,
	input  logic [MaxCols-1:0] act_mask,
	output logic [MaxCols-1:0] next_row,
	output logic               changed
);

	logic [2:0]         col_bits [MaxCols];
	logic [MaxCols-1:0] chg;

	for (genvar i = 0; i < MaxCols; i++) begin : g_col
		logic [2:0] left;
		logic [2:0] right;

		if (i == 0) begin : g_left_edge
			assign left = 3'b000;
		end else begin : g_left
			assign left = col_bits[i-1];
		end

		if (i == MaxCols - 1) begin : g_right_edge
			assign right = 3'b000;
		end else begin : g_right
			assign right = col_bits[i+1];
		end

		lgs_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.in_bit   (row_in[i]),
			.act      (act_mask[i]),
			.nb_left  (left),
			.nb_right (right),
			.col_bits (col_bits[i]),
			.next_bit (next_row[i]),
			.changed  (chg[i])
		);
	end

	assign changed = |chg;

endmodule
